/* src/aeu_pkg.sv */
package aeu_pkg;

   // Field widths.
   localparam int TIME_W      = 22;
   localparam int LEN_W       = 20;
   localparam int LEVEL_W     = 15;
   localparam int STAGE_W     = 3;
   // Signed distance of a time index from a stage end.
   localparam int DIST_W      = TIME_W + 1;
   // Product of a ramp offset and a level step.
   localparam int PROD_W      = LEN_W + LEVEL_W;
   // One quotient bit per divider stage; the quotient never exceeds a level step.
   localparam int DIV_STEPS   = LEVEL_W;

   // Queue between the classifier and the arithmetic back end.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Register port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = LEN_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_ATTACK_LENGTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY_LENGTH   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUSTAIN_LENGTH = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_LENGTH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PEAK_LEVEL     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_LEVEL     = 3'd5;

   // Register values after reset.
   localparam logic [LEN_W-1:0]   RESET_ATTACK_LENGTH  = 20'd8000;
   localparam logic [LEN_W-1:0]   RESET_DECAY_LENGTH   = 20'd12000;
   localparam logic [LEN_W-1:0]   RESET_SUSTAIN_LENGTH = 20'd40000;
   localparam logic [LEN_W-1:0]   RESET_RELEASE_LENGTH = 20'd20000;
   localparam logic [LEVEL_W-1:0] RESET_PEAK_LEVEL     = 15'd2500;
   localparam logic [LEVEL_W-1:0] RESET_HOLD_LEVEL     = 15'd1500;

   typedef enum logic [STAGE_W-1:0] {
      STAGE_ATTACK  = 3'd0,
      STAGE_DECAY   = 3'd1,
      STAGE_SUSTAIN = 3'd2,
      STAGE_RELEASE = 3'd3,
      STAGE_DONE    = 3'd4
   } stage_type;

   typedef struct packed {
      logic [LEN_W-1:0]   attack_length;
      logic [LEN_W-1:0]   decay_length;
      logic [LEN_W-1:0]   sustain_length;
      logic [LEN_W-1:0]   release_length;
      logic [LEVEL_W-1:0] peak_level;
      logic [LEVEL_W-1:0] hold_level;
   } cfg_type;

   // One classified item: level = start -/+ ramp(offset * delta / length).
   typedef struct packed {
      stage_type          stage;
      logic [LEVEL_W-1:0] start_level;
      logic [LEVEL_W-1:0] delta;
      logic               down;
      logic [LEN_W-1:0]   offset;
      logic [LEN_W-1:0]   length;
   } job_type;

endpackage

/* src/aeu_req_if.sv */
interface aeu_req_if import aeu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] time_index;

   modport source (output valid, output time_index, input ready);
   modport sink (input valid, input time_index, output ready);
endinterface

/* src/aeu_rsp_if.sv */
interface aeu_rsp_if import aeu_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] level;
   logic [STAGE_W-1:0] stage;

   modport source (output valid, output level, output stage, input ready);
   modport sink (input valid, input level, input stage, output ready);
endinterface

/* src/adsr_envelope_level_unit.sv */
// Linear ADSR envelope level: one beat in, one beat out, in order.
// Path from request to result: four classifier stages, the queue, the multiplier,
// a 15-stage divider and the output register.
// Throughput: one beat per cycle unless stalled; a four-entry queue lets each half stall on its own.
// Reset (synchronous, active high) empties all stages and loads the default registers.
module adsr_envelope_level_unit import aeu_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   aeu_req_if.sink                req_ch,
   aeu_rsp_if.source              rsp_ch,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    front_valid, front_ready;
   job_type front_job;
   logic    back_valid, back_ready;
   job_type back_job;

   // Register writes; bits above a register's width and unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ATTACK_LENGTH:  cfg_in.attack_length  = csr_data[LEN_W-1:0];
            CSR_DECAY_LENGTH:   cfg_in.decay_length   = csr_data[LEN_W-1:0];
            CSR_SUSTAIN_LENGTH: cfg_in.sustain_length = csr_data[LEN_W-1:0];
            CSR_RELEASE_LENGTH: cfg_in.release_length = csr_data[LEN_W-1:0];
            CSR_PEAK_LEVEL:     cfg_in.peak_level     = csr_data[LEVEL_W-1:0];
            CSR_HOLD_LEVEL:     cfg_in.hold_level     = csr_data[LEVEL_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_length  <= RESET_ATTACK_LENGTH;
         cfg_ff.decay_length   <= RESET_DECAY_LENGTH;
         cfg_ff.sustain_length <= RESET_SUSTAIN_LENGTH;
         cfg_ff.release_length <= RESET_RELEASE_LENGTH;
         cfg_ff.peak_level     <= RESET_PEAK_LEVEL;
         cfg_ff.hold_level     <= RESET_HOLD_LEVEL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   aeu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .cfg       (cfg_ff),
      .job_valid (front_valid),
      .job       (front_job),
      .job_ready (front_ready)
   );

   aeu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_data  (front_job),
      .push_ready (front_ready),
      .pop_valid  (back_valid),
      .pop_data   (back_job),
      .pop_ready  (back_ready)
   );

   aeu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (back_valid),
      .job       (back_job),
      .job_ready (back_ready),
      .rsp       (rsp_ch)
   );

   // A sustain beat carries the hold level unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.stage == STAGE_SUSTAIN) |-> rsp_ch.level == cfg_ff.hold_level)
      else $error("sustain level differs from hold level");

   // The attack never overshoots the peak.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.stage == STAGE_ATTACK) |-> rsp_ch.level <= cfg_ff.peak_level)
      else $error("attack level above peak");

endmodule

/* src/aeu_front.sv */
module aeu_front import aeu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   aeu_req_if.sink req,
   input  cfg_type cfg,
   output logic    job_valid,
   output job_type job,
   input  logic    job_ready
);

   // Distances of the time index from each stage end, one subtraction per stage.
   typedef struct packed {
      logic [TIME_W-1:0] t;
      logic [DIST_W-1:0] r1;
      logic [DIST_W-1:0] r2;
      logic [DIST_W-1:0] r3;
      logic [DIST_W-1:0] r4;
   } front_stage_type;

   function automatic logic at_or_before(input logic [DIST_W-1:0] r);
      return r[DIST_W-1] | (r == '0);
   endfunction

   front_stage_type    s1_ff, s2_ff, s3_ff, s4_ff;
   front_stage_type    s1_in, s2_in, s3_in, s4_in;
   logic [3:0]         valid_ff;
   logic               advance;
   logic [LEVEL_W-1:0] end_level;

   // The whole front moves together whenever its last stage can hand over.
   assign advance   = !valid_ff[3] || job_ready;
   assign req.ready = advance;
   assign job_valid = valid_ff[3];

   always_comb begin
      s1_in    = '0;
      s1_in.t  = req.time_index;
      s1_in.r1 = {1'b0, req.time_index} - {{(DIST_W-LEN_W){1'b0}}, cfg.attack_length};
      s2_in    = s1_ff;
      s2_in.r2 = s1_ff.r1 - {{(DIST_W-LEN_W){1'b0}}, cfg.decay_length};
      s3_in    = s2_ff;
      s3_in.r3 = s2_ff.r2 - {{(DIST_W-LEN_W){1'b0}}, cfg.sustain_length};
      s4_in    = s3_ff;
      s4_in.r4 = s3_ff.r3 - {{(DIST_W-LEN_W){1'b0}}, cfg.release_length};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[2:0], req.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   // Classify the item and set up its ramp. A zero-length stage gives its end level.
   always_comb begin
      job       = '0;
      end_level = '0;
      if (at_or_before(s4_ff.r1)) begin
         job.stage       = STAGE_ATTACK;
         job.start_level = '0;
         job.delta       = cfg.peak_level;
         job.down        = 1'b0;
         job.offset      = s4_ff.t[LEN_W-1:0];
         job.length      = cfg.attack_length;
         end_level       = cfg.peak_level;
      end else if (at_or_before(s4_ff.r2)) begin
         job.stage       = STAGE_DECAY;
         job.start_level = cfg.peak_level;
         job.down        = cfg.hold_level < cfg.peak_level;
         job.delta       = job.down ? cfg.peak_level - cfg.hold_level
                                    : cfg.hold_level - cfg.peak_level;
         job.offset      = s4_ff.r1[LEN_W-1:0];
         job.length      = cfg.decay_length;
         end_level       = cfg.hold_level;
      end else if (at_or_before(s4_ff.r3)) begin
         job.stage       = STAGE_SUSTAIN;
         job.start_level = cfg.hold_level;
         job.length      = LEN_W'(1);
         end_level       = cfg.hold_level;
      end else if (at_or_before(s4_ff.r4)) begin
         job.stage       = STAGE_RELEASE;
         job.start_level = cfg.hold_level;
         job.delta       = cfg.hold_level;
         job.down        = 1'b1;
         job.offset      = s4_ff.r3[LEN_W-1:0];
         job.length      = cfg.release_length;
      end else begin
         job.stage       = STAGE_DONE;
         job.length      = LEN_W'(1);
      end
      if (job.length == '0) begin
         job.start_level = end_level;
         job.delta       = '0;
         job.offset      = '0;
         job.length      = LEN_W'(1);
      end
   end

endmodule

/* src/aeu_queue.sv */
module aeu_queue import aeu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  job_type push_data,
   output logic    push_ready,
   output logic    pop_valid,
   output job_type pop_data,
   input  logic    pop_ready
);

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                push, pop;

   assign push_ready = count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill count update; pointers wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QUEUE_AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QUEUE_AW'(1);
      end
      count_in = count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The fill count never passes the depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("queue fill count above depth");

   // The fill count follows the beats pushed and popped.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         count_ff == $past(count_ff) + (QUEUE_AW+1)'($past(push))
                     - (QUEUE_AW+1)'($past(pop)))
      else $error("queue fill count out of step with push and pop");

endmodule

/* src/aeu_back.sv */
module aeu_back import aeu_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      job_valid,
   input  job_type   job,
   output logic      job_ready,
   aeu_rsp_if.source rsp
);

   typedef struct packed {
      logic [PROD_W-1:0]  prod;
      logic [LEN_W-1:0]   length;
      logic [LEVEL_W-1:0] start_level;
      logic               down;
      stage_type          stage;
   } mul_stage_type;

   // Partial remainder and dividend bits still to come, which turn into quotient bits.
   typedef struct packed {
      logic [LEN_W-1:0]   rem;
      logic [LEVEL_W-1:0] lo;
      logic [LEN_W-1:0]   length;
      logic [LEVEL_W-1:0] start_level;
      logic               down;
      stage_type          stage;
   } div_stage_type;

   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type  n;
      logic [LEN_W:0] trial;
      logic           qbit;
      n     = s;
      trial = {s.rem, s.lo[LEVEL_W-1]};
      qbit  = trial >= {1'b0, s.length};
      if (qbit) begin
         n.rem = LEN_W'(trial - {1'b0, s.length});
      end else begin
         n.rem = trial[LEN_W-1:0];
      end
      n.lo = {s.lo[LEVEL_W-2:0], qbit};
      return n;
   endfunction

   mul_stage_type          mul_ff, mul_in;
   logic                   mul_valid_ff;
   div_stage_type          div_ff [DIV_STEPS];
   div_stage_type          div_first;
   logic [DIV_STEPS-1:0]   div_valid_ff;
   logic                   out_valid_ff;
   logic [LEVEL_W-1:0]     out_level_ff, out_level_in;
   stage_type              out_stage_ff;
   logic                   advance;

   // The back end moves as one whenever the output register is free or being taken.
   assign advance   = !out_valid_ff || rsp.ready;
   assign job_ready = advance;

   // Multiply the ramp offset by the level step.
   always_comb begin
      mul_in.prod        = PROD_W'(job.offset) * PROD_W'(job.delta);
      mul_in.length      = job.length;
      mul_in.start_level = job.start_level;
      mul_in.down        = job.down;
      mul_in.stage       = job.stage;
   end

   // The upper product bits stay below the length, so one quotient bit per step suffices.
   always_comb begin
      div_first.rem         = mul_ff.prod[PROD_W-1 -: LEN_W];
      div_first.lo          = mul_ff.prod[LEVEL_W-1:0];
      div_first.length      = mul_ff.length;
      div_first.start_level = mul_ff.start_level;
      div_first.down        = mul_ff.down;
      div_first.stage       = mul_ff.stage;
   end

   // Floor for rising ramps, ceiling subtracted for falling ones.
   always_comb begin
      if (div_ff[DIV_STEPS-1].down) begin
         out_level_in = div_ff[DIV_STEPS-1].start_level - div_ff[DIV_STEPS-1].lo
                        - LEVEL_W'(div_ff[DIV_STEPS-1].rem != '0);
      end else begin
         out_level_in = div_ff[DIV_STEPS-1].start_level + div_ff[DIV_STEPS-1].lo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         div_valid_ff <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= job_valid;
         div_valid_ff <= {div_valid_ff[DIV_STEPS-2:0], mul_valid_ff};
         out_valid_ff <= div_valid_ff[DIV_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_ff    <= mul_in;
         div_ff[0] <= div_step(div_first);
         for (int k = 1; k < DIV_STEPS; k++) begin
            div_ff[k] <= div_step(div_ff[k-1]);
         end
         out_level_ff <= out_level_in;
         out_stage_ff <= div_ff[DIV_STEPS-1].stage;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.level = out_level_ff;
   assign rsp.stage = out_stage_ff;

   // Past the release the level is always zero.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_stage_ff == STAGE_DONE) |-> out_level_ff == '0)
      else $error("nonzero level after release");

endmodule

/* bench/adsr_envelope_level_unit_test.sv */
module adsr_envelope_level_unit_test;
   import aeu_pkg::*;

   localparam int CLOCK_PERIOD    = 4;
   localparam int RUN_LIMIT       = 2_000_000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_CYCLES     = 300;
   localparam int PRESSURE_BEATS  = 80;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 142;
   localparam int DIRECTED_ROWS   = 39;

   localparam longint unsigned TIME_MAX = (64'd1 << TIME_W) - 1;

   // Register indexes that the block has no register behind.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 3'd7;

   typedef enum logic {ROW_LOOKUP, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [TIME_W-1:0]      value;
      logic                   typed;
      logic [LEVEL_W-1:0]     level;
      stage_type              stage;
   } stimulus_row_type;

   typedef struct packed {
      logic [TIME_W-1:0]  time_index;
      logic [LEVEL_W-1:0] level;
      stage_type          stage;
   } envelope_point_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   aeu_req_if req_ch ();
   aeu_rsp_if rsp_ch ();

   adsr_envelope_level_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Our own copy of the envelope registers, and the levels still owed by the block.
   cfg_type            envelope_regs;
   envelope_point_type awaited_points [$];

   int fault_count;
   int lookups_sent;
   int beats_checked;
   int settings_used;
   int hold_requests;
   int holds_served;
   int ready_left;
   int stage_hits [0:4];

   // Directed lookups: default registers, then lengths and peak at maximum with hold zero, then empty stages.
   stimulus_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{ROW_LOOKUP, '0, 22'd0,       1'b1, 15'd0,     STAGE_ATTACK},
      '{ROW_LOOKUP, '0, 22'd1,       1'b0, 15'd0,     STAGE_ATTACK},
      '{ROW_LOOKUP, '0, 22'd8000,    1'b1, 15'd2500,  STAGE_ATTACK},
      '{ROW_LOOKUP, '0, 22'd8001,    1'b0, 15'd0,     STAGE_ATTACK},
      '{ROW_LOOKUP, '0, 22'd20000,   1'b1, 15'd1500,  STAGE_DECAY},
      '{ROW_LOOKUP, '0, 22'd60000,   1'b1, 15'd1500,  STAGE_SUSTAIN},
      '{ROW_LOOKUP, '0, 22'd70000,   1'b0, 15'd0,     STAGE_ATTACK},
      '{ROW_LOOKUP, '0, 22'd80000,   1'b1, 15'd0,     STAGE_RELEASE},
      '{ROW_LOOKUP, '0, 22'd80001,   1'b1, 15'd0,     STAGE_DONE},
      '{ROW_LOOKUP, '0, 22'd4194303, 1'b1, 15'd0,     STAGE_DONE},
      '{ROW_WRITE,  CSR_ATTACK_LENGTH,  22'hFFFFF, 1'b0, 15'd0, STAGE_ATTACK},
      '{ROW_WRITE,  CSR_DECAY_LENGTH,   22'hFFFFF, 1'b0, 15'd0, STAGE_ATTACK},
      '{ROW_WRITE,  CSR_SUSTAIN_LENGTH, 22'hFFFFF, 1'b0, 15'd0, STAGE_ATTACK},
      '{ROW_WRITE,  CSR_RELEASE_LENGTH, 22'hFFFFF, 1'b0, 15'd0, STAGE_ATTACK},
      '{ROW_WRITE,  CSR_PEAK_LEVEL,     22'hFFFFF, 1'b0, 15'd0, STAGE_ATTACK},
      '{ROW_WRITE,  CSR_HOLD_LEVEL,     22'h00000, 1'b0, 15'd0, STAGE_ATTACK},
      '{ROW_LOOKUP, '0, 22'd4194300, 1'b1, 15'd0,     STAGE_RELEASE},
      '{ROW_LOOKUP, '0, 22'd4194301, 1'b1, 15'd0,     STAGE_DONE},
      '{ROW_LOOKUP, '0, 22'd1048575, 1'b1, 15'd32767, STAGE_ATTACK},
      '{ROW_LOOKUP, '0, 22'd2097150, 1'b1, 15'd0,     STAGE_DECAY},
      '{ROW_LOOKUP, '0, 22'd3000000, 1'b0, 15'd0,     STAGE_ATTACK},
      '{ROW_LOOKUP, '0, 22'd524288,  1'b0, 15'd0,     STAGE_ATTACK},
      '{ROW_WRITE,  CSR_ATTACK_LENGTH,  22'h00000, 1'b0, 15'd0, STAGE_ATTACK},
      '{ROW_WRITE,  CSR_DECAY_LENGTH,   22'h00000, 1'b0, 15'd0, STAGE_ATTACK},
      '{ROW_WRITE,  CSR_HOLD_LEVEL,     22'h504D2, 1'b0, 15'd0, STAGE_ATTACK},
      '{ROW_WRITE,  CSR_SPARE_LOW,      22'h00005, 1'b0, 15'd0, STAGE_ATTACK},
      '{ROW_WRITE,  CSR_SPARE_HIGH,     22'hFFFFF, 1'b0, 15'd0, STAGE_ATTACK},
      '{ROW_LOOKUP, '0, 22'd0,       1'b1, 15'd32767, STAGE_ATTACK},
      '{ROW_LOOKUP, '0, 22'd1,       1'b1, 15'd1234,  STAGE_SUSTAIN},
      '{ROW_WRITE,  CSR_SUSTAIN_LENGTH, 22'h00000, 1'b0, 15'd0, STAGE_ATTACK},
      '{ROW_WRITE,  CSR_RELEASE_LENGTH, 22'h00000, 1'b0, 15'd0, STAGE_ATTACK},
      '{ROW_LOOKUP, '0, 22'd0,       1'b1, 15'd32767, STAGE_ATTACK},
      '{ROW_LOOKUP, '0, 22'd1,       1'b1, 15'd0,     STAGE_DONE},
      '{ROW_WRITE,  CSR_RELEASE_LENGTH, 22'h00005, 1'b0, 15'd0, STAGE_ATTACK},
      '{ROW_LOOKUP, '0, 22'd3,       1'b0, 15'd0,     STAGE_ATTACK},
      '{ROW_LOOKUP, '0, 22'd5,       1'b1, 15'd0,     STAGE_RELEASE},
      '{ROW_WRITE,  CSR_ATTACK_LENGTH,  22'h00001, 1'b0, 15'd0, STAGE_ATTACK},
      '{ROW_LOOKUP, '0, 22'd1,       1'b1, 15'd32767, STAGE_ATTACK},
      '{ROW_LOOKUP, '0, 22'd2,       1'b0, 15'd0,     STAGE_ATTACK}
   };

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // A straight line between two levels; rising ramps round down, falling ones round up,
   // which is the floor of the signed step in both cases.
   function automatic logic [LEVEL_W-1:0] ramp_level(input longint unsigned from_level,
                                                     input longint unsigned to_level,
                                                     input longint unsigned offset,
                                                     input longint unsigned span);
      if (span == 0) begin
         return LEVEL_W'(to_level);
      end
      if (offset > span) begin
         offset = span;
      end
      if (to_level >= from_level) begin
         return LEVEL_W'(from_level + (offset * (to_level - from_level)) / span);
      end
      return LEVEL_W'(from_level - (offset * (from_level - to_level) + span - 1) / span);
   endfunction

   // Envelope level and stage at one time index under the current registers.
   function automatic envelope_point_type envelope_at(input logic [TIME_W-1:0] t);
      envelope_point_type point;
      longint unsigned    at;
      longint unsigned    e1;
      longint unsigned    e2;
      longint unsigned    e3;
      longint unsigned    e4;
      at = t;
      e1 = envelope_regs.attack_length;
      e2 = e1 + envelope_regs.decay_length;
      e3 = e2 + envelope_regs.sustain_length;
      e4 = e3 + envelope_regs.release_length;
      point.time_index = t;
      if (at <= e1) begin
         point.level = ramp_level(0, envelope_regs.peak_level, at,
                                  envelope_regs.attack_length);
         point.stage = STAGE_ATTACK;
      end else if (at <= e2) begin
         point.level = ramp_level(envelope_regs.peak_level, envelope_regs.hold_level,
                                  at - e1, envelope_regs.decay_length);
         point.stage = STAGE_DECAY;
      end else if (at <= e3) begin
         point.level = envelope_regs.hold_level;
         point.stage = STAGE_SUSTAIN;
      end else if (at <= e4) begin
         point.level = ramp_level(envelope_regs.hold_level, 0, at - e3,
                                  envelope_regs.release_length);
         point.stage = STAGE_RELEASE;
      end else begin
         point.level = '0;
         point.stage = STAGE_DONE;
      end
      return point;
   endfunction

   // Times close to a stage end, times within or just past the envelope, each four in ten; else anything.
   function automatic logic [TIME_W-1:0] pick_time();
      longint unsigned stage_ends [4];
      longint signed   probe;
      longint unsigned reach;
      stage_ends[0] = envelope_regs.attack_length;
      stage_ends[1] = stage_ends[0] + envelope_regs.decay_length;
      stage_ends[2] = stage_ends[1] + envelope_regs.sustain_length;
      stage_ends[3] = stage_ends[2] + envelope_regs.release_length;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            probe = longint'(stage_ends[$urandom_range(0, 3)]) +
                    longint'($urandom_range(0, 4)) - 2;
            if (probe < 0) begin
               probe = 0;
            end
            if (probe > longint'(TIME_MAX)) begin
               probe = longint'(TIME_MAX);
            end
            return probe[TIME_W-1:0];
         end
         4, 5, 6, 7: begin
            reach = stage_ends[3] + stage_ends[3] / 8 + 4;
            if (reach > TIME_MAX) begin
               reach = TIME_MAX;
            end
            return TIME_W'($urandom_range(0, int'(reach)));
         end
         default: begin
            return TIME_W'($urandom);
         end
      endcase
   endfunction

   function automatic logic [LEN_W-1:0] random_length();
      case ($urandom_range(0, 11))
         0: return '0;
         1: return LEN_W'(1);
         2: return '1;
         3, 4, 5: return LEN_W'($urandom_range(2, 64));
         6, 7, 8: return LEN_W'($urandom_range(65, 5000));
         default: return LEN_W'($urandom_range(1, (1 << LEN_W) - 1));
      endcase
   endfunction

   // Level writes carry random junk above the register width, which must be dropped.
   function automatic logic [CSR_DATA_W-1:0] random_level_data();
      logic [LEVEL_W-1:0] lvl;
      case ($urandom_range(0, 5))
         0: lvl = '0;
         1: lvl = '1;
         default: lvl = LEVEL_W'($urandom);
      endcase
      return {(CSR_DATA_W - LEVEL_W)'($urandom), lvl};
   endfunction

   task automatic report_fault(input string text);
      $display("[%0t] mismatch: %s", $time, text);
      fault_count++;
   endtask

   task automatic check_beat(input logic [LEVEL_W-1:0] got_level,
                             input logic [STAGE_W-1:0] got_stage);
      envelope_point_type want;
      if (awaited_points.size() == 0) begin
         report_fault($sformatf("beat with nothing awaited: level %0d stage %0d",
                                got_level, got_stage));
         return;
      end
      want = awaited_points.pop_front();
      if (got_level !== want.level) begin
         report_fault($sformatf("t=%0d level %0d, expected %0d",
                                want.time_index, got_level, want.level));
      end
      if (got_stage !== want.stage) begin
         report_fault($sformatf("t=%0d stage %0d, expected %0d",
                                want.time_index, got_stage, want.stage));
      end
      stage_hits[want.stage]++;
      beats_checked++;
   endtask

   // Result side: check every beat, and stall on a pattern of its own.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         check_beat(rsp_ch.level, rsp_ch.stage);
      end
      if (reset) begin
         ready_left = 0;
         rsp_ch.ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         ready_left = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (ready_left != 0) begin
         ready_left--;
      end else if ($urandom_range(0, 2) != 0) begin
         rsp_ch.ready <= 1'b1;
         ready_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(0, 20);
      end else begin
         rsp_ch.ready <= 1'b0;
         ready_left = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12)
                                                  : $urandom_range(0, 3);
      end
   end

   // Offer one lookup and hold it until accepted; valid stays high for a following beat.
   task automatic push_time(input logic [TIME_W-1:0] t, input logic typed,
                            input logic [LEVEL_W-1:0] typed_level,
                            input stage_type typed_stage);
      envelope_point_type point;
      req_ch.valid      <= 1'b1;
      req_ch.time_index <= t;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      if (typed) begin
         point = '{time_index: t, level: typed_level, stage: typed_stage};
      end else begin
         point = envelope_at(t);
      end
      awaited_points.push_back(point);
      lookups_sent++;
   endtask

   task automatic idle_cycles(input int count);
      req_ch.valid <= 1'b0;
      repeat (count) @(posedge clock);
   endtask

   // Stop offering, let every awaited beat arrive, then let the pipeline settle.
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      while (awaited_points.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      case (index)
         CSR_ATTACK_LENGTH:  envelope_regs.attack_length  = data[LEN_W-1:0];
         CSR_DECAY_LENGTH:   envelope_regs.decay_length   = data[LEN_W-1:0];
         CSR_SUSTAIN_LENGTH: envelope_regs.sustain_length = data[LEN_W-1:0];
         CSR_RELEASE_LENGTH: envelope_regs.release_length = data[LEN_W-1:0];
         CSR_PEAK_LEVEL:     envelope_regs.peak_level     = data[LEVEL_W-1:0];
         CSR_HOLD_LEVEL:     envelope_regs.hold_level     = data[LEVEL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic end_writes();
      csr_wr_en <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   task automatic load_random_settings();
      wait_for_drain();
      write_register(CSR_ATTACK_LENGTH, random_length());
      write_register(CSR_DECAY_LENGTH, random_length());
      write_register(CSR_SUSTAIN_LENGTH, random_length());
      write_register(CSR_RELEASE_LENGTH, random_length());
      write_register(CSR_PEAK_LEVEL, random_level_data());
      write_register(CSR_HOLD_LEVEL, random_level_data());
      if ($urandom_range(0, 3) == 0) begin
         write_register($urandom_range(0, 1) ? CSR_SPARE_LOW : CSR_SPARE_HIGH,
                        CSR_DATA_W'($urandom));
      end
      end_writes();
   endtask

   initial begin
      #(RUN_LIMIT);
      $display("Run timed out with %0d results still awaited", awaited_points.size());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic writing;
      int   burst_left;
      clock                = 1'b0;
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.time_index    = '0;
      rsp_ch.ready         = 1'b0;
      csr_wr_en            = 1'b0;
      csr_index            = '0;
      csr_data             = '0;
      fault_count          = 0;
      lookups_sent         = 0;
      beats_checked        = 0;
      settings_used        = 1;
      hold_requests        = 0;
      holds_served         = 0;
      stage_hits           = '{default: 0};
      envelope_regs        = '{attack_length:  RESET_ATTACK_LENGTH,
                               decay_length:   RESET_DECAY_LENGTH,
                               sustain_length: RESET_SUSTAIN_LENGTH,
                               release_length: RESET_RELEASE_LENGTH,
                               peak_level:     RESET_PEAK_LEVEL,
                               hold_level:     RESET_HOLD_LEVEL};
      writing    = 1'b0;
      burst_left = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part: register writes wait for the block to go idle.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            if (!writing) begin
               wait_for_drain();
               writing = 1'b1;
            end
            write_register(directed_rows[i].reg_index,
                           directed_rows[i].value[CSR_DATA_W-1:0]);
         end else begin
            if (writing) begin
               end_writes();
               writing = 1'b0;
            end
            push_time(directed_rows[i].value, directed_rows[i].typed,
                      directed_rows[i].level, directed_rows[i].stage);
         end
      end

      // Random part: fresh registers for each phase, lookups sent in bursts.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_random_settings();
         if (phase == 2) begin
            // Long receiver hold-off while beats keep coming, so the input backs up.
            hold_requests <= hold_requests + 1;
         end
         burst_left = 0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (!(phase == 2 && n < PRESSURE_BEATS)) begin
               if (burst_left == 0) begin
                  idle_cycles($urandom_range(1, 24));
                  burst_left = ($urandom_range(0, 4) == 0) ? 150 : $urandom_range(1, 40);
               end
               burst_left--;
            end
            push_time(pick_time(), 1'b0, '0, STAGE_ATTACK);
         end
      end

      wait_for_drain();

      $display("Covered %0d envelope lookups under %0d register settings, %s%0d-cycle hold-off.",
               lookups_sent, settings_used, "with one ", HOLD_CYCLES);
      $display("Beats checked %0d: attack %0d, decay %0d, sustain %0d, release %0d, done %0d.",
               beats_checked, stage_hits[0], stage_hits[1], stage_hits[2], stage_hits[3],
               stage_hits[4]);
      if (fault_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
